FILE: rtl/core/bced_pkg.sv
// ----------------------------------------------------------------------------
// bced_pkg
// Shared types, constants and codes for the button click event detector.
// ----------------------------------------------------------------------------
package bced_pkg;

	localparam int BUTTONS      = 4;
	localparam int VOTE_SAMPLES = 5;

	localparam int BTN_W   = 2;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int CODE_W  = 3;
	localparam int SLOT_W  = $clog2(VOTE_SAMPLES + 1);
	localparam int CNT_W   = $clog2(VOTE_SAMPLES + 1);
	localparam int CFG_IDX_W = 3;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	localparam logic [MS_W-1:0] LONG_PRESS_RST   = MS_W'(1000);
	localparam logic [MS_W-1:0] HOLD_START_RST   = MS_W'(2000);
	localparam logic [MS_W-1:0] HOLD_PERIOD_RST  = MS_W'(500);
	localparam logic [MS_W-1:0] REPEAT_START_RST = MS_W'(300);
	localparam logic [MS_W-1:0] REPEAT_PERIOD_RST = MS_W'(200);
	localparam logic [MS_W-1:0] CLICK_GAP_RST    = MS_W'(500);

	typedef enum logic [CODE_W-1:0] {
		EV_DOWN   = 3'd0,
		EV_UP     = 3'd1,
		EV_SINGLE = 3'd2,
		EV_DOUBLE = 3'd3,
		EV_LONG   = 3'd4,
		EV_HOLD   = 3'd5,
		EV_REPEAT = 3'd6
	} ev_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_LEVEL   = 3'd0,
		CFG_LONG_PRESS    = 3'd1,
		CFG_HOLD_START    = 3'd2,
		CFG_HOLD_PERIOD   = 3'd3,
		CFG_REPEAT_START  = 3'd4,
		CFG_REPEAT_PERIOD = 3'd5,
		CFG_CLICK_GAP     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic            press_level;
		logic [MS_W-1:0] long_press_ms;
		logic [MS_W-1:0] hold_start_ms;
		logic [MS_W-1:0] hold_period_ms;
		logic [MS_W-1:0] repeat_start_ms;
		logic [MS_W-1:0] repeat_period_ms;
		logic [MS_W-1:0] click_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [VOTE_SAMPLES-1:0] vote_window;
		logic [SLOT_W-1:0]       vote_slot;
		logic                    stable_level;
		logic [TIME_W-1:0]       press_start;
		logic                    long_seen;
		logic [1:0]              clicks;
		logic [TIME_W-1:0]       last_click;
		logic [TIME_W-1:0]       last_hold;
		logic [TIME_W-1:0]       last_repeat;
	} btn_state_t;

	typedef struct packed {
		logic [BTN_W-1:0] button;
		ev_code_t         code;
		logic             last;
	} event_t;

	typedef struct packed {
		logic [1:0] n;
		ev_code_t   code0;
		ev_code_t   code1;
	} step_res_t;

endpackage

FILE: rtl/core/bced_cfg_regs.sv
// ----------------------------------------------------------------------------
// bced_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module bced_cfg_regs
	import bced_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level      <= 1'b0;
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
			cfg_q.hold_start_ms    <= HOLD_START_RST;
			cfg_q.hold_period_ms   <= HOLD_PERIOD_RST;
			cfg_q.repeat_start_ms  <= REPEAT_START_RST;
			cfg_q.repeat_period_ms <= REPEAT_PERIOD_RST;
			cfg_q.click_gap_ms     <= CLICK_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRESS_LEVEL:   cfg_q.press_level      <= cfg_data[0];
				CFG_LONG_PRESS:    cfg_q.long_press_ms    <= cfg_data;
				CFG_HOLD_START:    cfg_q.hold_start_ms    <= cfg_data;
				CFG_HOLD_PERIOD:   cfg_q.hold_period_ms   <= cfg_data;
				CFG_REPEAT_START:  cfg_q.repeat_start_ms  <= cfg_data;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= cfg_data;
				CFG_CLICK_GAP:     cfg_q.click_gap_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bced_step.sv
// ----------------------------------------------------------------------------
// bced_step
// Per-scan logic: majority vote debounce, press timing and event selection.
// ----------------------------------------------------------------------------
module bced_step
	import bced_pkg::*;
(
	input  cfg_t              cfg,
	input  btn_state_t        cur,
	input  logic [BTN_W-1:0]  button,
	input  logic              raw_level,
	input  logic [TIME_W-1:0] now_ms,
	output btn_state_t        nxt,
	output step_res_t         res
);

	logic                    in_range;
	logic [SLOT_W-1:0]       slot;
	logic [VOTE_SAMPLES-1:0] mask;
	logic [VOTE_SAMPLES-1:0] win;
	logic [CNT_W-1:0]        count;
	logic                    pressed;
	logic [TIME_W-1:0]       dur;
	logic [TIME_W-1:0]       gap;
	logic [TIME_W-1:0]       since_hold;
	logic [TIME_W-1:0]       since_repeat;
	logic [TIME_W-1:0]       long_thr;
	logic [1:0]              clicks_inc;

	assign in_range = ({1'b0, button} < (BTN_W + 1)'(BUTTONS));
	assign slot = (cur.vote_slot >= SLOT_W'(VOTE_SAMPLES)) ? '0 : cur.vote_slot;
	assign mask = VOTE_SAMPLES'(1) << slot;
	assign win = (raw_level == cfg.press_level) ? (cur.vote_window | mask)
		: (cur.vote_window & ~mask);
	assign count = CNT_W'($countones(win));
	assign pressed = (count > CNT_W'(VOTE_SAMPLES / 2));
	assign dur = now_ms - cur.press_start;
	assign gap = now_ms - cur.last_click;
	assign since_hold = now_ms - cur.last_hold;
	assign since_repeat = now_ms - cur.last_repeat;
	assign long_thr = TIME_W'(cfg.long_press_ms);
	assign clicks_inc = cur.clicks + 2'd1;

	always_comb begin
		nxt = cur;
		res.n = 2'd0;
		res.code0 = EV_DOWN;
		res.code1 = EV_DOWN;
		if (in_range) begin
			nxt.vote_window = win;
			nxt.vote_slot = (slot == SLOT_W'(VOTE_SAMPLES - 1)) ? '0 : slot + SLOT_W'(1);
			if (pressed != cur.stable_level) begin
				nxt.stable_level = pressed;
				if (pressed) begin
					nxt.press_start = now_ms;
					nxt.long_seen = 1'b0;
					nxt.last_hold = '0;
					nxt.last_repeat = '0;
					res.code0 = EV_DOWN;
					res.n = 2'd1;
				end else begin
					res.code0 = EV_UP;
					res.n = 2'd1;
					if (dur < long_thr) begin
						nxt.last_click = now_ms;
						nxt.clicks = clicks_inc;
						if (clicks_inc == 2'd2) begin
							res.n = 2'd2;
							if (gap < TIME_W'(cfg.click_gap_ms)) begin
								res.code1 = EV_DOUBLE;
								nxt.clicks = 2'd0;
							end else begin
								res.code1 = EV_SINGLE;
								nxt.clicks = 2'd1;
							end
						end
					end else begin
						nxt.clicks = 2'd0;
					end
				end
			end else if (pressed) begin
				if (!cur.long_seen && (dur > long_thr)) begin
					res.code0 = EV_LONG;
					res.n = 2'd1;
					nxt.long_seen = 1'b1;
					nxt.clicks = 2'd0;
				end
				if (nxt.long_seen && (dur > TIME_W'(cfg.hold_start_ms))
						&& (since_hold > TIME_W'(cfg.hold_period_ms))) begin
					if (res.n == 2'd0) begin
						res.code0 = EV_HOLD;
					end else begin
						res.code1 = EV_HOLD;
					end
					res.n = res.n + 2'd1;
					nxt.last_hold = now_ms;
				end
				if ((res.n < 2'd2) && (dur > TIME_W'(cfg.repeat_start_ms)) && (dur < long_thr)
						&& (since_repeat > TIME_W'(cfg.repeat_period_ms))) begin
					if (res.n == 2'd0) begin
						res.code0 = EV_REPEAT;
					end else begin
						res.code1 = EV_REPEAT;
					end
					res.n = res.n + 2'd1;
					nxt.last_repeat = now_ms;
				end
			end else begin
				if ((cur.clicks == 2'd1) && (gap > TIME_W'(cfg.click_gap_ms))) begin
					res.code0 = EV_SINGLE;
					res.n = 2'd1;
					nxt.clicks = 2'd0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/bced_evq.sv
// ----------------------------------------------------------------------------
// bced_evq
// Event queue: takes up to two events per cycle, delivers one per request.
// ----------------------------------------------------------------------------
module bced_evq
	import bced_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  event_t            ent0,
	input  event_t            ent1,
	output logic              room,
	output logic              m_tvalid,
	input  logic              m_tready,
	output event_t            head
);

	event_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign m_tvalid = (count_q != '0);
	assign pop = m_tvalid && m_tready;
	assign room = (count_q <= QCNT_W'(QDEPTH - 2));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= ent0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= ent1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

endmodule

FILE: rtl/core/button_click_event_detector.sv
// ----------------------------------------------------------------------------
// button_click_event_detector
// Debounces button scans and reports press, click, long-press, hold and repeat events.
// ----------------------------------------------------------------------------
// Pipeline: an accepted scan is registered in the input stage and evaluated from
//   there; its events are written to the event queue that feeds the master side.
// Throughput: one scan per cycle, bounded by the output at one event per cycle;
//   the input stalls while the four-entry event queue holds more than two events.
// Reset: all button state, the queue pointers and the input valid flag clear; the
//   configuration registers take their reset values.
module button_click_event_detector
	import bced_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // button[1:0], raw_level[2], now_ms[34:3]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // event_button[1:0], event_code[4:2]
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data
);

	cfg_t              cfg;
	logic              s1_valid;
	logic [BTN_W-1:0]  button_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	btn_state_t        btn_q [BUTTONS];
	btn_state_t        cur;
	btn_state_t        nxt;
	step_res_t         res;
	logic              room;
	logic              advance;
	logic [1:0]        push_n;
	event_t            ent0;
	event_t            ent1;
	event_t            head;

	bced_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance = s1_valid && room;
	assign s_tready = !s1_valid || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			button_s1 <= s_tdata[1:0];
			raw_s1 <= s_tdata[2];
			now_s1 <= s_tdata[34:3];
		end
	end

	assign cur = btn_q[button_s1];

	bced_step u_step (
		.cfg       (cfg),
		.cur       (cur),
		.button    (button_s1),
		.raw_level (raw_s1),
		.now_ms    (now_s1),
		.nxt       (nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				btn_q[i] <= '0;
			end
		end else if (advance) begin
			btn_q[button_s1] <= nxt;
		end
	end

	assign push_n = advance ? res.n : 2'd0;
	assign ent0 = '{button: button_s1, code: res.code0, last: (res.n == 2'd1)};
	assign ent1 = '{button: button_s1, code: res.code1, last: 1'b1};

	bced_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.ent0     (ent0),
		.ent1     (ent1),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {3'b000, head.code, head.button};
	assign m_tlast = head.last;

endmodule

FILE: rtl/core/bced_checker.sv
// ----------------------------------------------------------------------------
// bced_checker
// Port-level checks on the event stream of the button click event detector.
// ----------------------------------------------------------------------------
module bced_checker
	import bced_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic                m_tlast
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:2] <= EV_REPEAT) && (m_tdata[7:5] == 3'b000))
		else $error("invalid event code");

	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[4:2] == EV_UP) || (m_tdata[4:2] == EV_LONG)
			|| (m_tdata[4:2] == EV_HOLD))
		else $error("non-final event is neither release, long start nor hold");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (.*);
